### design/assert_macros.svh
// Assertion macros for the checker file of the MPPT duty block.
// Each use expands to one labeled concurrent assertion on the given clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPLIES(lbl, c, r, ante, cons) \
  lbl: assert property (@(posedge c) disable iff (r) (ante) |-> (cons)) \
    else $error("mppt duty check failed");

// next-cycle implication
`define CHK_NEXT(lbl, c, r, ante, cons) \
  lbl: assert property (@(posedge c) disable iff (r) (ante) |=> (cons)) \
    else $error("mppt duty check failed");

`endif

### design/pom_pkg.sv
// Package for the perturb-and-observe MPPT duty block: types, codes, constants.
// No dependencies; used by every module of the block.
package pom_pkg;

  localparam int DUTY_FULL_SCALE     = 100;
  localparam int DUTY_TRACK_MAX      = 99;
  localparam int POWER_FRACTION_BITS = 16;

  localparam logic [15:0] GAIN_RESET   = 16'd655;
  localparam logic [3:0]  STEP_RESET   = 4'd1;
  localparam logic [15:0] PERIOD_RESET = 16'd120;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic [1:0] REG_GAIN   = 2'd0;
  localparam logic [1:0] REG_STEP   = 2'd1;
  localparam logic [1:0] REG_PERIOD = 2'd2;

  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_START  = 2'd1;
  localparam logic [1:0] CMD_MANUAL = 2'd2;

  // shared multiplier operand / product widths
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;

  // exact floor division by reciprocal for 32-bit unsigned operands
  localparam logic [31:0] RECIP5         = 32'hCCCC_CCCD;
  localparam int          RECIP5_SHIFT   = 34;
  localparam logic [31:0] RECIP100       = 32'h51EB_851F;
  localparam int          RECIP100_SHIFT = 37;

  typedef struct packed {
    logic [15:0] gain;
    logic [3:0]  step;
    logic [15:0] period;
  } cfg_t;

  typedef struct packed {
    logic [15:0]        compare;
    logic [6:0]         duty;
    logic               tracking;
    logic signed [29:0] power;
  } res_t;

endpackage

### design/pom_mul.sv
// Shared signed multiplier of the MPPT duty block, product registered.
// Depends on pom_pkg for operand widths.
module pom_mul (
  input  logic                                clk,
  input  logic signed [pom_pkg::MUL_W-1:0]    a,
  input  logic signed [pom_pkg::MUL_W-1:0]    b,
  output logic signed [pom_pkg::PROD_W-1:0]   p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

### design/pom_cfg.sv
// APB register file of the MPPT duty block: gain, step size, PWM period.
// Depends on pom_pkg for register indexes, reset values and cfg_t.
module pom_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pom_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [pom_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [pom_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  output pom_pkg::cfg_t                     cfg
);

  logic [1:0] index;
  logic       wr;

  assign index  = paddr[3:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain   <= pom_pkg::GAIN_RESET;
      cfg.step   <= pom_pkg::STEP_RESET;
      cfg.period <= pom_pkg::PERIOD_RESET;
    end else if (wr) begin
      if (index == pom_pkg::REG_GAIN) begin
        cfg.gain <= pwdata[15:0];
      end
      if (index == pom_pkg::REG_STEP) begin
        cfg.step <= pwdata[3:0];
      end
      if (index == pom_pkg::REG_PERIOD) begin
        cfg.period <= pwdata[15:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    unique case (index)
      pom_pkg::REG_GAIN:   prdata = {16'b0, cfg.gain};
      pom_pkg::REG_STEP:   prdata = {28'b0, cfg.step};
      pom_pkg::REG_PERIOD: prdata = {16'b0, cfg.period};
      default:             prdata = '0;
    endcase
  end

endmodule

### design/pom_core.sv
// Sequencer and datapath of the MPPT duty block around one shared multiplier.
// Depends on pom_pkg and pom_mul.
module pom_core #(
  parameter int FRAC_BITS = pom_pkg::POWER_FRACTION_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  pom_pkg::cfg_t       cfg,
  input  logic                start,
  output logic                idle,
  input  logic [1:0]          cmd,
  input  logic [14:0]         bus_mv,
  input  logic signed [15:0]  shunt,
  input  logic [6:0]          manual,
  output logic                done,
  input  logic                take,
  output pom_pkg::res_t       res
);

  localparam int AW  = FRAC_BITS + 32;   // average width
  localparam int DW  = AW + 1;           // difference width
  localparam int QW  = 28;               // quotient of |bus*shunt| / 5
  localparam int SW  = QW + FRAC_BITS;   // sample magnitude width
  localparam int CPW = 23;               // duty * period width
  localparam int MW  = pom_pkg::MUL_W;

  localparam logic [FRAC_BITS-1:0] FRAC1 = FRAC_BITS'((64'd1 << FRAC_BITS) / 5);
  localparam logic [FRAC_BITS-1:0] FRAC2 = FRAC_BITS'((64'd2 << FRAC_BITS) / 5);
  localparam logic [FRAC_BITS-1:0] FRAC3 = FRAC_BITS'((64'd3 << FRAC_BITS) / 5);
  localparam logic [FRAC_BITS-1:0] FRAC4 = FRAC_BITS'((64'd4 << FRAC_BITS) / 5);

  typedef enum logic [14:0] {
    ST_IDLE = 15'b000000000000001,
    ST_PMUL = 15'b000000000000010,
    ST_ABS  = 15'b000000000000100,
    ST_QMUL = 15'b000000000001000,
    ST_QREM = 15'b000000000010000,
    ST_DIFF = 15'b000000000100000,
    ST_LMUL = 15'b000000001000000,
    ST_HMUL = 15'b000000010000000,
    ST_ACC  = 15'b000000100000000,
    ST_UPD  = 15'b000001000000000,
    ST_DUTY = 15'b000010000000000,
    ST_CMUL = 15'b000100000000000,
    ST_DMUL = 15'b001000000000000,
    ST_CDIV = 15'b010000000000000,
    ST_DONE = 15'b100000000000000
  } state_t;

  state_t state;

  logic [AW-1:0]  avg;
  logic [AW-1:0]  prev;
  logic           dir;
  logic [6:0]     duty;
  logic           tracking;
  logic [15:0]    compare;

  logic [14:0]    bus_r;
  logic [15:0]    shunt_r;
  logic           neg;
  logic [29:0]    mag;
  logic [SW-1:0]  smag;
  logic [DW-1:0]  diff;
  logic [31:0]    acc;
  logic [DW-1:0]  stepv;

  logic signed [MW-1:0]                mul_a;
  logic signed [MW-1:0]                mul_b;
  logic signed [pom_pkg::PROD_W-1:0]   prod;

  logic [QW-1:0]        quo;
  logic [2:0]           rem;
  logic [FRAC_BITS-1:0] frac;
  logic [DW-1:0]        smp;
  logic [DW-1:0]        sample;
  logic [30:0]          pw;
  logic                 rising;
  logic                 dir_new;
  logic [7:0]           dsum;
  logic [6:0]           duty_next;
  logic [6:0]           man_sat;

  pom_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_PMUL: begin
        mul_a = {18'b0, bus_r};
        mul_b = {{17{shunt_r[15]}}, shunt_r};
      end
      ST_QMUL: begin
        mul_a = {3'b0, mag};
        mul_b = {1'b0, pom_pkg::RECIP5};
      end
      ST_LMUL: begin
        mul_a = {1'b0, diff[31:0]};
        mul_b = {17'b0, cfg.gain};
      end
      ST_HMUL: begin
        mul_a = MW'($signed(diff[DW-1:32]));
        mul_b = {17'b0, cfg.gain};
      end
      ST_CMUL: begin
        mul_a = {26'b0, duty};
        mul_b = {17'b0, cfg.period};
      end
      ST_DMUL: begin
        mul_a = {10'b0, prod[CPW-1:0]};
        mul_b = {1'b0, pom_pkg::RECIP100};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // remainder of |bus*shunt| / 5 from the low bits only
  assign pw  = prod[30:0];
  assign quo = prod[pom_pkg::RECIP5_SHIFT+QW-1:pom_pkg::RECIP5_SHIFT];
  assign rem = mag[2:0] - {quo[0], 2'b00} - quo[2:0];

  always_comb begin
    unique case (rem)
      3'd1:    frac = FRAC1;
      3'd2:    frac = FRAC2;
      3'd3:    frac = FRAC3;
      3'd4:    frac = FRAC4;
      default: frac = '0;
    endcase
  end

  assign smp    = {{(DW-SW){1'b0}}, smag};
  assign sample = neg ? (~smp + 1'b1) : smp;

  assign rising  = $signed(avg) > $signed(prev);
  assign dir_new = rising ? dir : !dir;
  assign dsum    = {1'b0, duty} + {4'b0, cfg.step};

  always_comb begin
    if (dir_new) begin
      duty_next = (dsum > 8'(pom_pkg::DUTY_TRACK_MAX)) ?
                  7'(pom_pkg::DUTY_TRACK_MAX) : dsum[6:0];
    end else begin
      duty_next = ({3'b0, cfg.step} > duty) ? 7'd0 : (duty - {3'b0, cfg.step});
    end
  end

  assign man_sat = (manual > 7'(pom_pkg::DUTY_FULL_SCALE)) ?
                   7'(pom_pkg::DUTY_FULL_SCALE) : manual;

  // control and tracker state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      avg      <= '0;
      prev     <= '0;
      dir      <= 1'b1;
      duty     <= '0;
      tracking <= 1'b0;
      compare  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            if (cmd == pom_pkg::CMD_MANUAL) begin
              tracking <= 1'b0;
              duty     <= man_sat;
              state    <= ST_CMUL;
            end else if (cmd == pom_pkg::CMD_START) begin
              tracking <= 1'b1;
              duty     <= {3'b0, cfg.step} + 7'd1;
              state    <= ST_PMUL;
            end else if (tracking) begin
              state <= ST_PMUL;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_PMUL: state <= ST_ABS;
        ST_ABS:  state <= ST_QMUL;
        ST_QMUL: state <= ST_QREM;
        ST_QREM: state <= ST_DIFF;
        ST_DIFF: state <= ST_LMUL;
        ST_LMUL: state <= ST_HMUL;
        ST_HMUL: state <= ST_ACC;
        ST_ACC:  state <= ST_UPD;
        ST_UPD: begin
          avg   <= avg + stepv[AW-1:0];
          state <= ST_DUTY;
        end
        ST_DUTY: begin
          dir   <= dir_new;
          prev  <= avg;
          duty  <= duty_next;
          state <= ST_CMUL;
        end
        ST_CMUL: state <= ST_DMUL;
        ST_DMUL: state <= ST_CDIV;
        ST_CDIV: begin
          compare <= prod[pom_pkg::RECIP100_SHIFT+15:pom_pkg::RECIP100_SHIFT];
          state   <= ST_DONE;
        end
        ST_DONE: begin
          if (take) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath work registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      bus_r   <= bus_mv;
      shunt_r <= shunt;
    end
    if (state == ST_ABS) begin
      neg <= pw[30];
      mag <= pw[30] ? 30'(~pw + 1'b1) : pw[29:0];
    end
    if (state == ST_QREM) begin
      smag <= {quo, frac};
    end
    if (state == ST_DIFF) begin
      diff <= sample - {avg[AW-1], avg};
    end
    if (state == ST_HMUL) begin
      acc <= prod[47:16];
    end
    if (state == ST_ACC) begin
      stepv <= {prod[DW-17:0], 16'b0} + {{(DW-32){1'b0}}, acc};
    end
  end

  assign idle         = (state == ST_IDLE);
  assign done         = (state == ST_DONE);
  assign res.compare  = compare;
  assign res.duty     = duty;
  assign res.tracking = tracking;
  assign res.power    = $signed(avg[FRAC_BITS+29:FRAC_BITS]);

endmodule

### design/perturb_observe_mppt_duty_unit.sv
// Top level of the perturb-and-observe MPPT duty block: ports, result register.
// Depends on pom_pkg, pom_cfg and pom_core.
//
//   channel   handshake                      payload
//   sample    sample_valid / sample_ready    cmd, bus_millivolts, shunt_reading, manual_duty
//   result    result_valid / result_ready    compare_value, duty_percent, tracking_on,
//                                            smoothed_power
//   config    APB psel/penable/pwrite        paddr, pwdata, prdata (pready tied high)
//
// One item is in the sequencer at a time; a tracking step uses the shared 33x33
// multiplier six times in turn.
// sample_ready is high only while the sequencer is idle.
// A finished item waits in the sequencer while the result register is full.
// rst is synchronous; it restores register defaults and resets all tracker state.
module perturb_observe_mppt_duty_unit #(
  parameter int POWER_FRAC_BITS = pom_pkg::POWER_FRACTION_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              sample_valid,
  output logic                              sample_ready,
  input  logic [1:0]                        cmd,
  input  logic [14:0]                       bus_millivolts,
  input  logic signed [15:0]                shunt_reading,
  input  logic [6:0]                        manual_duty,
  output logic                              result_valid,
  input  logic                              result_ready,
  output logic [15:0]                       compare_value,
  output logic [6:0]                        duty_percent,
  output logic                              tracking_on,
  output logic signed [29:0]                smoothed_power,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pom_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [pom_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [pom_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);

  pom_pkg::cfg_t cfg;
  pom_pkg::res_t res;
  logic          core_idle;
  logic          core_done;
  logic          load;

  pom_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pom_core #(
    .FRAC_BITS (POWER_FRAC_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .start  (sample_valid && sample_ready),
    .idle   (core_idle),
    .cmd    (cmd),
    .bus_mv (bus_millivolts),
    .shunt  (shunt_reading),
    .manual (manual_duty),
    .done   (core_done),
    .take   (load),
    .res    (res)
  );

  assign sample_ready = core_idle;
  assign load         = core_done && (!result_valid || result_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      compare_value  <= res.compare;
      duty_percent   <= res.duty;
      tracking_on    <= res.tracking;
      smoothed_power <= res.power;
    end
  end

endmodule

### design/pom_checker.sv
// Port-level checks for the MPPT duty block, bound to the top level.
// Depends on assert_macros.svh and pom_pkg.
`include "assert_macros.svh"

module pom_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              sample_valid,
  input logic                              sample_ready,
  input logic                              result_valid,
  input logic                              result_ready,
  input logic [15:0]                       compare_value,
  input logic [6:0]                        duty_percent,
  input logic                              tracking_on,
  input logic signed [29:0]                smoothed_power
);

  `CHK_NEXT(a_result_hold, clk, rst, result_valid && !result_ready,
            result_valid && $stable(compare_value) && $stable(duty_percent) &&
            $stable(tracking_on) && $stable(smoothed_power))
  `CHK_NEXT(a_busy_after_accept, clk, rst, sample_valid && sample_ready, !sample_ready)
  `CHK_IMPLIES(a_duty_range, clk, rst, result_valid,
               duty_percent <= 7'(pom_pkg::DUTY_FULL_SCALE))
  `CHK_IMPLIES(a_track_clamp, clk, rst, result_valid && tracking_on,
               duty_percent <= 7'(pom_pkg::DUTY_TRACK_MAX))
  `CHK_IMPLIES(a_reset_clean, clk, rst, $fell(rst), !result_valid && sample_ready)

endmodule

bind perturb_observe_mppt_duty_unit pom_checker u_pom_checker (.*);

### verif/tb_perturb_observe_mppt_duty_unit.sv
// Self-checking testbench for perturb_observe_mppt_duty_unit: valid/ready sample and result
// channels, APB register writes and reads, with a built-in tracker model predicting each result.
// Depends on pom_pkg and the design files; reads no files.
`timescale 1ns / 1ps

module tb_perturb_observe_mppt_duty_unit;

  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int GAIN_SHIFT = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 20;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [14:0]        bus;
    logic signed [15:0] shunt;
    logic [6:0]         manual;
  } pv_sample_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_ready;
  logic [1:0] cmd = '0;
  logic [14:0] bus_millivolts = '0;
  logic signed [15:0] shunt_reading = '0;
  logic [6:0] manual_duty = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  logic [15:0] compare_value;
  logic [6:0] duty_percent;
  logic tracking_on;
  logic signed [29:0] smoothed_power;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [pom_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [pom_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [pom_pkg::APB_DATA_W-1:0] prdata;
  logic pready;

  perturb_observe_mppt_duty_unit uut (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_ready(sample_ready),
    .cmd(cmd), .bus_millivolts(bus_millivolts), .shunt_reading(shunt_reading),
    .manual_duty(manual_duty),
    .result_valid(result_valid), .result_ready(result_ready),
    .compare_value(compare_value), .duty_percent(duty_percent),
    .tracking_on(tracking_on), .smoothed_power(smoothed_power),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // tracker model state and register copies
  logic [15:0] gain_set = pom_pkg::GAIN_RESET;
  logic [3:0] step_set = pom_pkg::STEP_RESET;
  logic [15:0] period_set = pom_pkg::PERIOD_RESET;
  longint avg_q = 0;
  longint prior_q = 0;
  bit rising_dir = 1'b1;
  int duty_pct = 0;
  bit auto_mode = 1'b0;
  logic [15:0] cmp_cnt = '0;

  pv_sample_t pending_items[$];
  pom_pkg::res_t duty_reports_due[$];
  pv_sample_t in_flight;
  bit calm = 1'b0;
  int fails = 0;
  int items_sent = 0;
  int reports_checked = 0;
  int tracking_steps = 0;
  int settings_seen = 1;
  int cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("perturb_observe_mppt_duty_unit regression: fail");
      $finish;
    end
  end

  function automatic void load_duty(int d);
    duty_pct = d;
    cmp_cnt = 16'((d * int'(period_set)) / pom_pkg::DUTY_FULL_SCALE);
  endfunction

  function automatic void advance_tracker(pv_sample_t it);
    pom_pkg::res_t r;
    longint b, s, prod, mag, q, smp;
    logic signed [95:0] diff, scaled;
    int d;
    if (it.cmd == pom_pkg::CMD_MANUAL) begin
      auto_mode = 1'b0;
      load_duty((int'(it.manual) > pom_pkg::DUTY_FULL_SCALE) ?
                pom_pkg::DUTY_FULL_SCALE : int'(it.manual));
    end else begin
      if (it.cmd == pom_pkg::CMD_START) begin
        auto_mode = 1'b1;
        load_duty(1 + int'(step_set));
      end
      if (auto_mode) begin
        b = it.bus;
        s = $signed(it.shunt);
        prod = b * s;
        mag = (prod < 0) ? -prod : prod;
        q = (mag <<< pom_pkg::POWER_FRACTION_BITS) / 5;
        smp = (prod < 0) ? -q : q;
        diff = smp - avg_q;
        scaled = diff * $signed({1'b0, gain_set});
        avg_q = avg_q + longint'(scaled >>> GAIN_SHIFT);
        if (!(avg_q > prior_q)) rising_dir = !rising_dir;
        d = rising_dir ? duty_pct + int'(step_set) : duty_pct - int'(step_set);
        if (d < 0) d = 0;
        if (d > pom_pkg::DUTY_TRACK_MAX) d = pom_pkg::DUTY_TRACK_MAX;
        load_duty(d);
        prior_q = avg_q;
        tracking_steps++;
      end
    end
    r.compare = cmp_cnt;
    r.duty = duty_pct[6:0];
    r.tracking = auto_mode;
    r.power = 30'(avg_q >>> pom_pkg::POWER_FRACTION_BITS);
    duty_reports_due.push_back(r);
  endfunction

  // sample driver
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      if (sample_valid && sample_ready) begin
        advance_tracker(in_flight);
        items_sent++;
      end
      if (!sample_valid || sample_ready) begin
        if (pending_items.size() > 0 && (calm || $urandom_range(99) >= 7)) begin
          in_flight = pending_items.pop_front();
          sample_valid <= 1'b1;
          cmd <= in_flight.cmd;
          bus_millivolts <= in_flight.bus;
          shunt_reading <= in_flight.shunt;
          manual_duty <= in_flight.manual;
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    pom_pkg::res_t want;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (duty_reports_due.size() == 0) begin
          $error("result with no item outstanding");
          fails++;
        end else begin
          want = duty_reports_due.pop_front();
          reports_checked++;
          if (compare_value !== want.compare) begin
            $error("compare_value: expected %0d, got %0d", want.compare, compare_value);
            fails++;
          end
          if (duty_percent !== want.duty) begin
            $error("duty_percent: expected %0d, got %0d", want.duty, duty_percent);
            fails++;
          end
          if (tracking_on !== want.tracking) begin
            $error("tracking_on: expected %0d, got %0d", want.tracking, tracking_on);
            fails++;
          end
          if (smoothed_power !== want.power) begin
            $error("smoothed_power: expected %0d, got %0d", want.power, smoothed_power);
            fails++;
          end
        end
      end
      result_ready <= calm || ($urandom_range(99) >= 7);
    end
  end

  task automatic push_item(logic [1:0] c, logic [14:0] b, logic [15:0] s, logic [6:0] m);
    pv_sample_t it;
    it.cmd = c;
    it.bus = b;
    it.shunt = s;
    it.manual = m;
    pending_items.push_back(it);
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || sample_valid || duty_reports_due.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic read_reg(logic [1:0] idx, logic [31:0] want);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== want) begin
      $error("prdata reg %0d: expected %0d, got %0d", idx, want, prdata);
      fails++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_regs();
    read_reg(pom_pkg::REG_GAIN, {16'd0, gain_set});
    read_reg(pom_pkg::REG_STEP, {28'd0, step_set});
    read_reg(pom_pkg::REG_PERIOD, {16'd0, period_set});
  endtask

  task automatic set_config(logic [15:0] g, logic [3:0] st, logic [15:0] p);
    write_reg(pom_pkg::REG_GAIN, {16'd0, g});
    write_reg(pom_pkg::REG_STEP, {28'd0, st});
    write_reg(pom_pkg::REG_PERIOD, {16'd0, p});
    gain_set = g;
    step_set = st;
    period_set = p;
    settings_seen++;
    check_regs();
  endtask

  // mostly tracking runs with a wandering operating point, plus restarts,
  // manual overrides, spare commands and fully random items
  task automatic queue_random(int n);
    int bus, shunt, r, i;
    bit on;
    logic [1:0] c;
    logic [6:0] m;
    bus = $urandom_range(32767);
    shunt = int'($urandom_range(65535)) - 32768;
    push_item(pom_pkg::CMD_START, bus[14:0], shunt[15:0], 7'($urandom_range(127)));
    on = 1'b1;
    for (i = 1; i < n; i++) begin
      if ($urandom_range(19) == 0) begin
        bus = $urandom_range(32767);
        shunt = int'($urandom_range(65535)) - 32768;
      end else begin
        bus = bus + int'($urandom_range(2000)) - 1000;
        shunt = shunt + int'($urandom_range(3000)) - 1500;
        if (bus < 0) bus = 0;
        if (bus > 32767) bus = 32767;
        if (shunt < -32768) shunt = -32768;
        if (shunt > 32767) shunt = 32767;
      end
      m = 7'($urandom_range(127));
      r = $urandom_range(99);
      if (!on && r < 30) begin
        c = pom_pkg::CMD_START;
      end else if (r < 4) begin
        c = pom_pkg::CMD_START;
      end else if (r < 7) begin
        c = pom_pkg::CMD_MANUAL;
        if ($urandom_range(3) != 0) m = 7'($urandom_range(pom_pkg::DUTY_FULL_SCALE));
      end else if (r < 10) begin
        c = CMD_SPARE;
      end else if (r < 13) begin
        c = 2'($urandom_range(3));
        bus = $urandom_range(32767);
        shunt = int'($urandom_range(65535)) - 32768;
      end else begin
        c = pom_pkg::CMD_SAMPLE;
      end
      if (c == pom_pkg::CMD_START) on = 1'b1;
      if (c == pom_pkg::CMD_MANUAL) on = 1'b0;
      push_item(c, bus[14:0], shunt[15:0], m);
    end
  endtask

  initial begin
    int ph;
    logic [15:0] g;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    check_regs();

    // directed: idle samples, manual saturation, start, extremes, equal power
    push_item(pom_pkg::CMD_SAMPLE, 15'h7FFF, 16'h8000, 7'h7F);
    push_item(CMD_SPARE, 15'h0000, 16'h7FFF, 7'h00);
    push_item(pom_pkg::CMD_MANUAL, 15'h0000, 16'h0000, 7'h7F);
    push_item(pom_pkg::CMD_MANUAL, 15'h7FFF, 16'hFFFF, 7'd0);
    push_item(pom_pkg::CMD_MANUAL, 15'h0000, 16'h0000, 7'd100);
    push_item(pom_pkg::CMD_SAMPLE, 15'h7FFF, 16'h7FFF, 7'd5);
    push_item(pom_pkg::CMD_START, 15'h7FFF, 16'h7FFF, 7'd0);
    push_item(pom_pkg::CMD_SAMPLE, 15'h7FFF, 16'h7FFF, 7'd0);
    push_item(pom_pkg::CMD_SAMPLE, 15'h7FFF, 16'h7FFF, 7'd0);
    push_item(pom_pkg::CMD_SAMPLE, 15'h0000, 16'h0000, 7'd0);
    push_item(pom_pkg::CMD_SAMPLE, 15'h7FFF, 16'h8000, 7'd0);
    push_item(CMD_SPARE, 15'h7FFF, 16'h8000, 7'd0);
    push_item(pom_pkg::CMD_START, 15'h0001, 16'hFFFF, 7'd0);
    push_item(pom_pkg::CMD_SAMPLE, 15'h4000, 16'h5555, 7'd0);
    push_item(pom_pkg::CMD_SAMPLE, 15'h2AAA, 16'hAAAA, 7'h55);
    push_item(pom_pkg::CMD_SAMPLE, 15'h2AAA, 16'hAAAA, 7'h2A);
    push_item(pom_pkg::CMD_MANUAL, 15'h5555, 16'h0001, 7'd99);
    push_item(pom_pkg::CMD_SAMPLE, 15'h5555, 16'h0001, 7'd0);
    push_item(pom_pkg::CMD_START, 15'h0000, 16'h0000, 7'd0);
    queue_random(150);
    wait_drained();

    // register extremes; the first of these runs without any idling
    calm = 1'b1;
    set_config(16'hFFFF, 4'd10, 16'hFFFF);
    queue_random(200);
    wait_drained();
    calm = 1'b0;

    set_config(16'd0, 4'd0, 16'd0);
    queue_random(120);
    wait_drained();

    set_config(16'd1, 4'd15, 16'd1);
    queue_random(150);
    wait_drained();

    for (ph = 0; ph < 6; ph++) begin
      g = ($urandom_range(1) != 0) ? 16'($urandom_range(65535)) : 16'($urandom_range(4096));
      set_config(g, 4'($urandom_range(15)), 16'($urandom_range(65535)));
      queue_random(200);
      wait_drained();
    end

    $display("Sent %0d items across %0d register settings; %0d results checked,",
             items_sent, settings_seen, reports_checked);
    $display("%0d of the items ran a tracking step.", tracking_steps);
    if (fails == 0) begin
      $display("perturb_observe_mppt_duty_unit regression: pass");
    end else begin
      $display("perturb_observe_mppt_duty_unit regression: fail");
    end
    $finish;
  end

endmodule

### perturb_observe_mppt_duty_unit.f
+incdir+design
design/pom_pkg.sv
design/pom_mul.sv
design/pom_cfg.sv
design/pom_core.sv
design/perturb_observe_mppt_duty_unit.sv
design/pom_checker.sv
verif/tb_perturb_observe_mppt_duty_unit.sv
